// File: src/ppib_pkg.sv
// Shared constants, types and saturation helpers for the particle pool.
`default_nettype none
package ppib_pkg;

    localparam int SLOTS     = 64;
    localparam int FRAC_BITS = 16;
    localparam int SLOT_W    = 6;
    localparam int CNT_W     = 7;
    localparam int PROD_W    = 50;
    localparam int SH_W      = PROD_W - FRAC_BITS;
    localparam int SUM_W     = SH_W + 1;
    localparam int BPROD_W   = 49;
    localparam int BSH_W     = BPROD_W - FRAC_BITS;

    localparam logic FUNC_SPAWN = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    localparam logic [1:0] KIND_ACK    = 2'd0;
    localparam logic [1:0] KIND_RECORD = 2'd1;
    localparam logic [1:0] KIND_EMPTY  = 2'd2;

    localparam logic [2:0] CFG_GROUND = 3'd0;
    localparam logic [2:0] CFG_REST   = 3'd1;
    localparam logic [2:0] CFG_GX     = 3'd2;
    localparam logic [2:0] CFG_GY     = 3'd3;
    localparam logic [2:0] CFG_GZ     = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SP_WR,
        ST_GDT,
        ST_SCAN,
        ST_RD,
        ST_VEL,
        ST_MUL,
        ST_WB,
        ST_END
    } t_state;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] life;
        logic signed [31:0] size;
        logic signed [31:0] size_rate;
    } t_slot;

    localparam int MEM_W = $bits(t_slot);

    // Clamp a grown sum to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] x);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(64'sh7FFF_FFFF);
        lo = -SUM_W'(64'sh8000_0000);
        if (x > hi) begin
            return 32'sh7FFF_FFFF;
        end else if (x < lo) begin
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

    // a plus an already shifted product, saturated.
    function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                   input logic signed [SH_W-1:0] p);
        logic signed [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(p);
        return sat32(s);
    endfunction

    // Full product of a signed value with dt, floored by the fraction width.
    function automatic logic signed [SH_W-1:0] mul_dt(input logic signed [31:0] a,
                                                      input logic [16:0] dt);
        logic signed [PROD_W-1:0] p;
        p = PROD_W'(a) * PROD_W'($signed({1'b0, dt}));
        return p[PROD_W-1:FRAC_BITS];
    endfunction

endpackage
`default_nettype wire

// File: src/ppib_ram.sv
// Generic single write port RAM with registered read.
`default_nettype none
module ppib_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: src/particle_pool_integrate_bounce.sv
// Top level of the particle pool: sequencer, slot memory and integration datapath.
`default_nettype none
// The pool holds 64 particle slots in one slot memory with a registered read.
// A spawn word runs a next-fit search, which examines at most 64 slots (when
// the pool is full), and returns one acknowledge word. A tick word first
// multiplies gravity by dt, then scans the slots; each live slot passes
// through read with the bounce multiply, velocity update, dt multiplies and
// write back. One record word is emitted per live slot, or one empty word
// when no slot is live. Every result word waits while the output register
// is still held by the receiver. Liveness is kept in a flag per slot that
// reset clears, so the memory needs no clearing pass. The next word is
// accepted as soon as the sequencer is back in idle, even while the last
// result word still waits in the output register. Configuration writes take
// effect at once and are meant to be made while the block is idle.
module particle_pool_integrate_bounce (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [31:0]        i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_func,
    input  wire logic [16:0]        i_dt,
    input  wire logic signed [31:0] i_spawn_pos_x,
    input  wire logic signed [31:0] i_spawn_pos_y,
    input  wire logic signed [31:0] i_spawn_pos_z,
    input  wire logic signed [31:0] i_spawn_vel_x,
    input  wire logic signed [31:0] i_spawn_vel_y,
    input  wire logic signed [31:0] i_spawn_vel_z,
    input  wire logic [30:0]        i_spawn_life,
    input  wire logic signed [31:0] i_spawn_size,
    input  wire logic signed [31:0] i_spawn_size_rate,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [1:0]              o_kind,
    output logic [5:0]              o_slot,
    output logic signed [31:0]      o_out_pos_x,
    output logic signed [31:0]      o_out_pos_y,
    output logic signed [31:0]      o_out_pos_z,
    output logic signed [31:0]      o_out_life,
    output logic signed [31:0]      o_out_size,
    output logic                    o_expired,
    output logic [6:0]              o_live_count,
    output logic                    o_last
);

    localparam int SW = ppib_pkg::SLOT_W;
    localparam logic [SW-1:0] LAST_SLOT = SW'(ppib_pkg::SLOTS - 1);

    // Configuration registers.
    logic signed [31:0] r_ground;
    logic [16:0]        r_rest;
    logic signed [31:0] r_gx;
    logic signed [31:0] r_gy;
    logic signed [31:0] r_gz;

    // Control state.
    ppib_pkg::t_state           r_state;
    ppib_pkg::t_state           n_state;
    logic [ppib_pkg::SLOTS-1:0] r_live;
    logic [SW-1:0]              r_idx;
    logic [SW-1:0]              r_start;
    logic [ppib_pkg::CNT_W-1:0] r_n;
    logic [ppib_pkg::CNT_W-1:0] r_cnt;
    logic                       r_o_valid;

    // Latched input word.
    logic               r_func;
    logic [16:0]        r_dt;
    ppib_pkg::t_slot    r_sp;

    // Datapath registers for the slot at work.
    ppib_pkg::t_slot                    r_cur;
    logic signed [32:0]                 r_life_new;
    logic                               r_bounce;
    logic [ppib_pkg::BPROD_W-1:0]       r_bprod;
    logic signed [ppib_pkg::SH_W-1:0]   r_gdt_x;
    logic signed [ppib_pkg::SH_W-1:0]   r_gdt_y;
    logic signed [ppib_pkg::SH_W-1:0]   r_gdt_z;
    logic signed [31:0]                 r_vx;
    logic signed [31:0]                 r_vy;
    logic signed [31:0]                 r_vz;
    logic signed [ppib_pkg::SH_W-1:0]   r_pdx;
    logic signed [ppib_pkg::SH_W-1:0]   r_pdy;
    logic signed [ppib_pkg::SH_W-1:0]   r_pdz;
    logic signed [ppib_pkg::SH_W-1:0]   r_sdt;

    // Output register.
    logic [1:0]         r_kind;
    logic [SW-1:0]      r_slot;
    logic signed [31:0] r_px;
    logic signed [31:0] r_py;
    logic signed [31:0] r_pz;
    logic signed [31:0] r_olife;
    logic signed [31:0] r_osize;
    logic               r_exp;
    logic [6:0]         r_ocnt;
    logic               r_last;

    // Memory port.
    logic                       w_we;
    logic [SW-1:0]              w_waddr;
    ppib_pkg::t_slot            w_wdata;
    logic [SW-1:0]              w_raddr;
    logic [ppib_pkg::MEM_W-1:0] w_rdata;
    ppib_pkg::t_slot            w_rd;

    logic w_accept;
    logic w_out_free;
    logic w_expired;
    logic w_hi_live;
    logic w_emit;
    logic w_full;
    logic [SW-1:0] w_next_idx;
    logic signed [ppib_pkg::SUM_W-1:0] w_bsat_in;

    ppib_ram #(
        .WIDTH(ppib_pkg::MEM_W),
        .DEPTH(ppib_pkg::SLOTS)
    ) u_slot_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_rd       = ppib_pkg::t_slot'(w_rdata);
    assign w_accept   = i_valid && o_ready;
    assign w_out_free = !r_o_valid || i_ready;
    assign w_expired  = r_life_new <= 33'sd0;
    assign w_next_idx = (r_idx == LAST_SLOT) ? '0 : r_idx + SW'(1);
    assign w_full     = r_n == ppib_pkg::CNT_W'(ppib_pkg::SLOTS - 1);

    // Any live slot above the current index decides whether this record is the last one.
    always_comb begin
        w_hi_live = 1'b0;
        for (int j = 0; j < ppib_pkg::SLOTS; j++) begin
            if (r_live[j] && (SW'(j) > r_idx)) begin
                w_hi_live = 1'b1;
            end
        end
    end

    // A positive bounce product, shifted down; the upper bits only matter for saturation.
    assign w_bsat_in = ppib_pkg::SUM_W'($signed({1'b0, r_bprod[ppib_pkg::BPROD_W-1:
                                                   ppib_pkg::FRAC_BITS]}));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ppib_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = (i_func == ppib_pkg::FUNC_SPAWN) ? ppib_pkg::ST_SEARCH
                                                               : ppib_pkg::ST_GDT;
                end
            end
            ppib_pkg::ST_SEARCH: begin
                if (!r_live[r_idx] || w_full) begin
                    n_state = ppib_pkg::ST_SP_WR;
                end
            end
            ppib_pkg::ST_SP_WR: begin
                if (w_out_free) begin
                    n_state = ppib_pkg::ST_IDLE;
                end
            end
            ppib_pkg::ST_GDT: n_state = ppib_pkg::ST_SCAN;
            ppib_pkg::ST_SCAN: begin
                if (r_live[r_idx]) begin
                    n_state = ppib_pkg::ST_RD;
                end else if (r_idx == LAST_SLOT) begin
                    n_state = ppib_pkg::ST_END;
                end
            end
            ppib_pkg::ST_RD:  n_state = ppib_pkg::ST_VEL;
            ppib_pkg::ST_VEL: n_state = ppib_pkg::ST_MUL;
            ppib_pkg::ST_MUL: n_state = ppib_pkg::ST_WB;
            ppib_pkg::ST_WB: begin
                if (w_out_free) begin
                    n_state = (r_idx == LAST_SLOT) ? ppib_pkg::ST_END : ppib_pkg::ST_SCAN;
                end
            end
            ppib_pkg::ST_END: begin
                if (r_cnt != '0) begin
                    n_state = ppib_pkg::ST_IDLE;
                end else if (w_out_free) begin
                    n_state = ppib_pkg::ST_IDLE;
                end
            end
            default: n_state = ppib_pkg::ST_IDLE;
        endcase
    end

    // Control outputs: memory port and output register load.
    always_comb begin
        o_ready = r_state == ppib_pkg::ST_IDLE;
        w_raddr = r_idx;
        w_waddr = r_idx;
        w_we    = 1'b0;
        w_emit  = 1'b0;
        w_wdata = r_sp;
        unique case (r_state)
            ppib_pkg::ST_SP_WR: begin
                w_we   = w_out_free;
                w_emit = w_out_free;
            end
            ppib_pkg::ST_WB: begin
                w_we          = w_out_free;
                w_emit        = w_out_free;
                w_wdata       = r_cur;
                w_wdata.life  = r_life_new[31:0];
                w_wdata.vel_x = r_vx;
                w_wdata.vel_y = r_vy;
                w_wdata.vel_z = r_vz;
                w_wdata.pos_x = ppib_pkg::add_sat(r_cur.pos_x, r_pdx);
                w_wdata.pos_y = ppib_pkg::add_sat(r_cur.pos_y, r_pdy);
                w_wdata.pos_z = ppib_pkg::add_sat(r_cur.pos_z, r_pdz);
                w_wdata.size  = ppib_pkg::add_sat(r_cur.size, r_sdt);
            end
            ppib_pkg::ST_END: begin
                w_emit = (r_cnt == '0) && w_out_free;
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ppib_pkg::ST_IDLE;
            r_live    <= '0;
            r_idx     <= '0;
            r_start   <= '0;
            r_n       <= '0;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
            r_ground  <= 32'sd0;
            r_rest    <= 17'd32768;
            r_gx      <= 32'sd0;
            r_gy      <= -32'sd642252;
            r_gz      <= 32'sd0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    ppib_pkg::CFG_GROUND: r_ground <= i_cfg_data;
                    ppib_pkg::CFG_REST:   r_rest   <= i_cfg_data[16:0];
                    ppib_pkg::CFG_GX:     r_gx     <= i_cfg_data;
                    ppib_pkg::CFG_GY:     r_gy     <= i_cfg_data;
                    ppib_pkg::CFG_GZ:     r_gz     <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (w_emit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                ppib_pkg::ST_IDLE: begin
                    if (w_accept) begin
                        r_n   <= '0;
                        r_cnt <= '0;
                        r_idx <= (i_func == ppib_pkg::FUNC_SPAWN) ? r_start : '0;
                    end
                end
                ppib_pkg::ST_SEARCH: begin
                    if (r_live[r_idx]) begin
                        if (w_full) begin
                            r_idx <= '0;
                        end else begin
                            r_idx <= w_next_idx;
                            r_n   <= r_n + ppib_pkg::CNT_W'(1);
                        end
                    end
                end
                ppib_pkg::ST_SP_WR: begin
                    if (w_out_free) begin
                        r_start       <= r_idx;
                        r_live[r_idx] <= r_sp.life != 32'sd0;
                    end
                end
                ppib_pkg::ST_SCAN: begin
                    if (!r_live[r_idx] && (r_idx != LAST_SLOT)) begin
                        r_idx <= w_next_idx;
                    end
                end
                ppib_pkg::ST_WB: begin
                    if (w_out_free) begin
                        r_cnt <= r_cnt + ppib_pkg::CNT_W'(1);
                        if (w_expired) begin
                            r_live[r_idx] <= 1'b0;
                        end
                        if (r_idx != LAST_SLOT) begin
                            r_idx <= w_next_idx;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Payload and datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func         <= i_func;
            r_dt           <= i_dt;
            r_sp.pos_x     <= i_spawn_pos_x;
            r_sp.pos_y     <= i_spawn_pos_y;
            r_sp.pos_z     <= i_spawn_pos_z;
            r_sp.vel_x     <= i_spawn_vel_x;
            r_sp.vel_y     <= i_spawn_vel_y;
            r_sp.vel_z     <= i_spawn_vel_z;
            r_sp.life      <= $signed({1'b0, i_spawn_life});
            r_sp.size      <= i_spawn_size;
            r_sp.size_rate <= i_spawn_size_rate;
        end
        if (r_state == ppib_pkg::ST_GDT) begin
            r_gdt_x <= ppib_pkg::mul_dt(r_gx, r_dt);
            r_gdt_y <= ppib_pkg::mul_dt(r_gy, r_dt);
            r_gdt_z <= ppib_pkg::mul_dt(r_gz, r_dt);
        end
        if (r_state == ppib_pkg::ST_RD) begin
            r_cur      <= w_rd;
            r_life_new <= 33'(w_rd.life) - $signed({16'd0, r_dt});
            r_bounce   <= (w_rd.pos_y <= r_ground) && (w_rd.vel_y < 32'sd0);
            // The negated velocity is only used when it is positive, up to 2^31.
            r_bprod    <= ppib_pkg::BPROD_W'(r_rest) *
                          ppib_pkg::BPROD_W'(-33'(w_rd.vel_y));
        end
        if (r_state == ppib_pkg::ST_VEL) begin
            r_vx <= ppib_pkg::add_sat(r_cur.vel_x, r_gdt_x);
            r_vy <= ppib_pkg::add_sat(r_bounce ? ppib_pkg::sat32(w_bsat_in) : r_cur.vel_y,
                                      r_gdt_y);
            r_vz <= ppib_pkg::add_sat(r_cur.vel_z, r_gdt_z);
        end
        if (r_state == ppib_pkg::ST_MUL) begin
            r_pdx <= ppib_pkg::mul_dt(r_vx, r_dt);
            r_pdy <= ppib_pkg::mul_dt(r_vy, r_dt);
            r_pdz <= ppib_pkg::mul_dt(r_vz, r_dt);
            r_sdt <= ppib_pkg::mul_dt(r_cur.size_rate, r_dt);
        end
        if (w_emit) begin
            r_slot  <= r_idx;
            r_px    <= 32'sd0;
            r_py    <= 32'sd0;
            r_pz    <= 32'sd0;
            r_olife <= 32'sd0;
            r_osize <= 32'sd0;
            r_exp   <= 1'b0;
            r_ocnt  <= '0;
            r_last  <= 1'b1;
            unique case (r_state)
                ppib_pkg::ST_SP_WR: r_kind <= ppib_pkg::KIND_ACK;
                ppib_pkg::ST_WB: begin
                    r_kind  <= ppib_pkg::KIND_RECORD;
                    r_olife <= r_life_new[31:0];
                    r_exp   <= w_expired;
                    r_ocnt  <= r_cnt + ppib_pkg::CNT_W'(1);
                    r_last  <= !w_hi_live || (r_idx == LAST_SLOT);
                    if (!w_expired) begin
                        r_px    <= w_wdata.pos_x;
                        r_py    <= w_wdata.pos_y;
                        r_pz    <= w_wdata.pos_z;
                        r_osize <= w_wdata.size;
                    end
                end
                default: begin
                    r_kind <= ppib_pkg::KIND_EMPTY;
                    r_slot <= '0;
                end
            endcase
        end
    end

    assign o_valid      = r_o_valid;
    assign o_kind       = r_kind;
    assign o_slot       = r_slot;
    assign o_out_pos_x  = r_px;
    assign o_out_pos_y  = r_py;
    assign o_out_pos_z  = r_pz;
    assign o_out_life   = r_olife;
    assign o_out_size   = r_osize;
    assign o_expired    = r_exp;
    assign o_live_count = r_ocnt;
    assign o_last       = r_last;

    // A spawn word always starts the free-slot search.
    a_spawn_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_func == ppib_pkg::FUNC_SPAWN) |=> r_state == ppib_pkg::ST_SEARCH)
        else $error("spawn did not start search");

    // The record count of a tick never passes the pool size.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= ppib_pkg::CNT_W'(ppib_pkg::SLOTS))
        else $error("record count out of range");

    // An acknowledge is always the final word of its spawn.
    a_ack_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == ppib_pkg::KIND_ACK) |-> o_last)
        else $error("acknowledge without last");

    // A tick is latched whenever the datapath runs.
    a_tick_func: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ppib_pkg::ST_RD) |-> r_func == ppib_pkg::FUNC_TICK)
        else $error("slot update outside a tick");

endmodule
`default_nettype wire
